FILE: rtl/aihs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aihs_pkg: shared types and constants of the allowed-identifier hash set
// Transaction structs, item mode codes, hash constants and the controller
// state encoding.
// ----------------------------------------------------------------------------
package aihs_pkg;

   localparam int ENTRY_COUNT_W = 10;
   localparam int KEY_W         = 64;
   localparam int HASH_SHIFT    = 33;

   localparam logic [KEY_W-1:0] HASH_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [KEY_W-1:0] HASH_MUL_B = 64'hc4ceb9fe1a85ec53;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [KEY_W-1:0] pattern;
   } req_type;

   typedef struct packed {
      logic                     allowed;
      logic                     status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_HASH,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_REPLY
   } state_type;

endpackage

FILE: rtl/aihs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aihs_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aihs_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/allowed_id_hash_set_top.sv
`timescale 1ns / 1ps
// Insert and query first compute the hash, which runs through one shared 32x32 multiplier,
// three partial products per 64-bit multiply, and then probe the table slot by slot.
// A clear writes one slot per cycle on the RAM write port.
// After reset the block sweeps the table and accepts no transaction until the sweep is done.
// One item is worked on at a time.
// ----------------------------------------------------------------------------
// allowed_id_hash_set_top: membership filter for 64-bit identifiers
// Open-addressing table with linear probing, indexed by the murmur3 64-bit
// finalizer. Each slot holds a used flag and the key in one RAM word.
// ----------------------------------------------------------------------------
module allowed_id_hash_set_top
   import aihs_pkg::*;
#(
   parameter int TABLE_DEPTH  = 1024,
   parameter int MAX_PATTERNS = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
   localparam int WORD_W = KEY_W + 1;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] visited_ff, visited_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [1:0]       mode_ff, mode_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] x_ff, x_in;
   logic [KEY_W-1:0] acc_ff, acc_in;
   logic [1:0]       phase_ff, phase_in;
   logic             round_ff, round_in;
   logic             res_allowed_ff, res_allowed_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_prod;
   logic [KEY_W-1:0] mul_const;
   logic [KEY_W-1:0] mul_full;
   logic [KEY_W-1:0] req_key;
   logic [CNT_W+ENTRY_COUNT_W-1:0] count_ext;

   aihs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Low 64 bits of x * C from three 32x32 partial products, one per phase.
   assign mul_const = round_ff ? HASH_MUL_B : HASH_MUL_A;
   assign mul_a     = (phase_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b     = (phase_ff == 2'd1) ? mul_const[63:32] : mul_const[31:0];
   assign mul_prod  = 64'(mul_a) * 64'(mul_b);
   assign mul_full  = {acc_ff[63:32] + mul_prod[31:0], acc_ff[31:0]};

   assign req_key   = req_data.pattern;
   assign count_ext = {{ENTRY_COUNT_W{1'b0}}, held_ff};

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      pos_in         = pos_ff;
      visited_in     = visited_ff;
      held_in        = held_ff;
      mode_in        = mode_ff;
      key_in         = key_ff;
      x_in           = x_ff;
      acc_in         = acc_ff;
      phase_in       = phase_ff;
      round_in       = round_ff;
      res_allowed_in = res_allowed_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      req_stall      = 1'b1;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = sweep_ff;
      ram_wr_data    = {1'b0, key_ff};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = pos_ff + 1'b1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_REPLY;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in        = req_data.mode;
               key_in         = req_key;
               x_in           = req_key ^ (req_key >> HASH_SHIFT);
               phase_in       = 2'd0;
               round_in       = 1'b0;
               res_allowed_in = 1'b0;
               res_status_in  = 1'b0;
               case (req_data.mode)
                  MODE_CLEAR: begin
                     held_in  = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  MODE_INSERT: begin
                     state_in = ST_HASH;
                  end
                  MODE_QUERY: begin
                     if (held_ff == '0) begin
                        // An empty set lets every identifier through.
                        res_allowed_in = 1'b1;
                        state_in       = ST_REPLY;
                     end else begin
                        state_in = ST_HASH;
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_HASH: begin
            case (phase_ff)
               2'd0: begin
                  acc_in   = mul_prod;
                  phase_in = 2'd1;
               end
               2'd1: begin
                  acc_in   = mul_full;
                  phase_in = 2'd2;
               end
               default: begin
                  x_in     = mul_full ^ (mul_full >> HASH_SHIFT);
                  phase_in = 2'd0;
                  round_in = 1'b1;
                  if (round_ff) begin
                     state_in = ST_PROBE_RD;
                  end
               end
            endcase
         end
         ST_PROBE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = x_ff[IDX_W-1:0];
            pos_in      = x_ff[IDX_W-1:0];
            visited_in  = '0;
            state_in    = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            // The next slot is read ahead so that one slot is checked per cycle.
            ram_rd_en = 1'b1;
            if (!ram_rd_data[KEY_W]) begin
               state_in = ST_REPLY;
               if (mode_ff == MODE_INSERT) begin
                  if (held_ff >= CNT_W'(MAX_PATTERNS)) begin
                     res_status_in = 1'b1;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = pos_ff;
                     ram_wr_data = {1'b1, key_ff};
                     held_in     = held_ff + 1'b1;
                  end
               end
            end else if (ram_rd_data[KEY_W-1:0] == key_ff) begin
               res_allowed_in = (mode_ff == MODE_QUERY);
               state_in       = ST_REPLY;
            end else if (visited_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               // Every slot is taken and none holds the key.
               res_status_in = (mode_ff == MODE_INSERT);
               state_in      = ST_REPLY;
            end else begin
               pos_in     = pos_ff + 1'b1;
               visited_in = visited_ff + 1'b1;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.allowed     = res_allowed_ff;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.entry_count = count_ext[ENTRY_COUNT_W-1:0];
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 2'd0;
         round_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         round_ff     <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      visited_ff     <= visited_in;
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      x_ff           <= x_in;
      acc_ff         <= acc_in;
      res_allowed_ff <= res_allowed_in;
      res_status_ff  <= res_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: dv/allowed_id_hash_set_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allowed_id_hash_set_top_test: self-checking testbench of the identifier set
// Drives clear, insert, query and unused-mode transactions into the block.
// A built-in hash set with linear probing predicts every result, and each
// result is compared field by field with the oldest prediction. The run
// covers directed corner cases and random traffic with colliding keys. It
// also fills the set past its pattern limit and applies several
// idle and stall mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module allowed_id_hash_set_top_test;
   import aihs_pkg::*;

   localparam int         TABLE_SLOTS   = 1024;
   localparam int         PATTERN_LIMIT = 512;
   localparam int         CYCLE_LIMIT   = 1000000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         TAIL_CYCLES   = 40;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   allowed_id_hash_set_top #(
      .TABLE_DEPTH  (TABLE_SLOTS),
      .MAX_PATTERNS (PATTERN_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Traffic control; the stimulus block writes the idle and hold settings on falling edges only.
   req_type     pending_items[$];
   rsp_type     expected_results[$];
   logic [63:0] issued_keys[$];
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          hold_request  = 1'b0;
   int          hold_left;
   int          cycle_count = 0;
   int          error_count = 0;
   int          results_checked = 0;

   // Predicted contents of the set.
   logic [63:0] stored_keys[TABLE_SLOTS];
   bit          slot_taken[TABLE_SLOTS];
   int          held = 0;
   int          peak_held = 0;
   int          clear_total = 0;
   int          insert_total = 0;
   int          reject_total = 0;
   int          query_total = 0;
   int          allow_total = 0;
   int          unused_total = 0;

   function automatic logic [63:0] murmur_mix(logic [63:0] x);
      x = x ^ (x >> HASH_SHIFT);
      x = x * HASH_MUL_A;
      x = x ^ (x >> HASH_SHIFT);
      x = x * HASH_MUL_B;
      x = x ^ (x >> HASH_SHIFT);
      return x;
   endfunction

   function automatic int home_slot(logic [63:0] key);
      logic [63:0] mixed;
      mixed = murmur_mix(key);
      return int'(mixed[31:0] & (TABLE_SLOTS - 1));
   endfunction

   // Walks the probe chain; free_slot gets the first empty slot met, or
   // TABLE_SLOTS when the key is met first or the whole table was visited without one.
   function automatic bit find_key(input logic [63:0] key, output int free_slot);
      int pos;
      pos = home_slot(key);
      free_slot = TABLE_SLOTS;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (!slot_taken[pos]) begin
            free_slot = pos;
            return 1'b0;
         end
         if (stored_keys[pos] == key)
            return 1'b1;
         pos = (pos == TABLE_SLOTS - 1) ? 0 : pos + 1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_item(req_type item);
      rsp_type result;
      int      free_slot;
      result = '0;
      case (item.mode)
         MODE_CLEAR: begin
            foreach (slot_taken[i])
               slot_taken[i] = 1'b0;
            held = 0;
            clear_total++;
         end
         MODE_INSERT: begin
            insert_total++;
            if (!find_key(item.pattern, free_slot)) begin
               if (held >= PATTERN_LIMIT || free_slot >= TABLE_SLOTS) begin
                  result.status = 1'b1;
                  reject_total++;
               end else begin
                  slot_taken[free_slot]  = 1'b1;
                  stored_keys[free_slot] = item.pattern;
                  held++;
                  if (held > peak_held)
                     peak_held = held;
               end
            end
         end
         MODE_QUERY: begin
            query_total++;
            // An empty set lets every identifier through.
            result.allowed = (held == 0) ? 1'b1 : find_key(item.pattern, free_slot);
            allow_total += result.allowed;
         end
         default: begin
            unused_total++;
         end
      endcase
      result.entry_count = held[ENTRY_COUNT_W-1:0];
      return result;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] key_at_slot(int slot);
      logic [63:0] key;
      do
         key = random_key();
      while (home_slot(key) != slot);
      return key;
   endfunction

   function automatic logic [63:0] issued_pick();
      return issued_keys[$urandom_range(issued_keys.size() - 1)];
   endfunction

   // A fresh key that lands on an occupied chain, or near the top of the
   // table so that probing wraps around to slot zero.
   function automatic logic [63:0] colliding_key();
      if (issued_keys.size() == 0 || $urandom_range(3) == 0)
         return key_at_slot(TABLE_SLOTS - 1 - $urandom_range(3));
      return key_at_slot(home_slot(issued_pick()));
   endfunction

   function automatic logic [63:0] insert_candidate();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15 && issued_keys.size() != 0)
         return issued_pick();
      if (pick < 30)
         return colliding_key();
      return random_key();
   endfunction

   function automatic logic [63:0] query_candidate();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50 && issued_keys.size() != 0)
         return issued_pick();
      if (pick < 70)
         return colliding_key();
      return random_key();
   endfunction

   task automatic add_item(logic [1:0] mode, logic [63:0] key);
      req_type item;
      item.mode    = mode;
      item.pattern = key;
      pending_items.push_back(item);
      if (mode == MODE_INSERT)
         issued_keys.push_back(key);
      else if (mode == MODE_CLEAR)
         issued_keys.delete();
   endtask

   task automatic add_mixed(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 2)
            add_item(MODE_CLEAR, random_key());
         else if (pick < 5)
            add_item(MODE_UNUSED, random_key());
         else if (pick < 50)
            add_item(MODE_INSERT, insert_candidate());
         else
            add_item(MODE_QUERY, query_candidate());
      end
   endtask

   // Fills the set well past its pattern limit so that late inserts are
   // rejected, then queries the full set.
   task automatic add_fill_run();
      int fresh;
      int pick;
      fresh = 0;
      add_item(MODE_CLEAR, random_key());
      while (fresh < PATTERN_LIMIT + 18) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            add_item(MODE_INSERT, (pick < 10) ? colliding_key() : random_key());
            fresh++;
         end else if (pick < 83 && issued_keys.size() != 0) begin
            add_item(MODE_INSERT, issued_pick());
         end else begin
            add_item(MODE_QUERY, query_candidate());
         end
      end
      repeat (20)
         add_item(MODE_QUERY, query_candidate());
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: a transaction is predicted at the edge where it is accepted.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      bit fire;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire)
            expected_results.push_back(predict_item(req_data));
         if (!req_valid || fire) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering.
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_request && hold_left == 0)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // ------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no transaction pending: allowed %0d status %0d count %0d",
                      rsp_data.allowed, rsp_data.status, rsp_data.entry_count);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_data.allowed !== want.allowed) begin
                  $error("allowed: expected %0d, got %0d", want.allowed, rsp_data.allowed);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_data.entry_count);
                  error_count++;
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [63:0] wrap_a;
      logic [63:0] wrap_b;
      logic [63:0] wrap_c;
      logic [63:0] wrap_absent;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases, no idling.
      set_idling(0, 0);
      wrap_a      = key_at_slot(TABLE_SLOTS - 1);
      wrap_b      = key_at_slot(TABLE_SLOTS - 1);
      wrap_c      = key_at_slot(TABLE_SLOTS - 1);
      wrap_absent = key_at_slot(TABLE_SLOTS - 1);
      add_item(MODE_QUERY,  64'h8000_0000_0000_0000);
      add_item(MODE_INSERT, 64'h8000_0000_0000_0000);
      add_item(MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
      add_item(MODE_INSERT, 64'h0);
      add_item(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
      add_item(MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
      add_item(MODE_QUERY,  64'h8000_0000_0000_0000);
      add_item(MODE_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
      add_item(MODE_QUERY,  random_key());
      add_item(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      // Three keys sharing the last home slot: the chain wraps to slot zero.
      add_item(MODE_INSERT, wrap_a);
      add_item(MODE_INSERT, wrap_b);
      add_item(MODE_INSERT, wrap_c);
      add_item(MODE_QUERY,  wrap_c);
      add_item(MODE_QUERY,  wrap_absent);
      add_item(MODE_CLEAR,  random_key());
      add_item(MODE_QUERY,  wrap_a);
      add_item(MODE_INSERT, wrap_absent);
      add_item(MODE_QUERY,  wrap_a);
      add_item(MODE_UNUSED, 64'h0);
      wait_drained();

      add_mixed(250);
      wait_drained();

      set_idling(78, 0);
      add_fill_run();
      wait_drained();

      set_idling(0, 78);
      add_mixed(250);
      wait_drained();

      set_idling(13, 13);
      add_mixed(250);
      wait_drained();

      // Receiver holds off while the sender keeps offering transactions.
      @(negedge clock);
      hold_request = 1'b1;
      add_mixed(90);
      @(negedge clock);
      hold_request = 1'b0;
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d inserts (%0d rejected as full), %0d queries",
               results_checked, insert_total, reject_total, query_total);
      $display("%0d queries allowed, %0d clears, %0d unused-mode items, peak count %0d",
               allow_total, clear_total, unused_total, peak_held);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
